// ===== rtl/core/rtpnal_pkg.sv =====
// types, constants and codes shared by the rtp nal packetizer
package rtpnal_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   // register index, taken from paddr bit 2
   localparam logic REG_VIDEO_CHANNEL = 1'b0;
   localparam logic REG_PAYLOAD_KIND  = 1'b1;

   localparam logic [7:0]  VIDEO_CHANNEL_RST = 8'd0;
   localparam logic [6:0]  PAYLOAD_KIND_RST  = 7'd96;

   localparam logic [10:0] MAX_PAYLOAD  = 11'd1400;
   localparam logic [10:0] RTP_HDR_LEN  = 11'd12;

   // prefix byte counts
   localparam logic [1:0] PCOUNT_SINGLE = 2'd0;
   localparam logic [1:0] PCOUNT_FUA    = 2'd2;
   localparam logic [1:0] PCOUNT_H265   = 2'd3;

   localparam logic [7:0] FUA_TYPE       = 8'd28;
   localparam logic [7:0] FUA_NRI_MASK   = 8'hE0;
   localparam logic [7:0] H265_FU_TYPE   = 8'd49;
   localparam logic [7:0] H265_KEEP_MASK = 8'h81;
   localparam logic [7:0] FU_START_BIT   = 8'h80;
   localparam logic [7:0] FU_END_BIT     = 8'h40;

   typedef struct packed {
      logic        is_h265;
      logic [7:0]  nal_head0;
      logic [7:0]  nal_head1;
      logic [15:0] nal_length;
      logic [31:0] timestamp;
      logic        unit_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  channel;
      logic [10:0] rtp_length;
      logic [7:0]  header_byte1;
      logic [15:0] sequence_res;
      logic [31:0] stamp_out;
      logic [1:0]  prefix_count;
      logic [7:0]  prefix0;
      logic [7:0]  prefix1;
      logic [7:0]  prefix2;
      logic [15:0] copy_offset;
      logic [10:0] copy_length;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic nal_empty;
      logic last_chunk;
   } status_type;

endpackage

// ===== rtl/core/rtpnal_ctrl.sv =====
// sequencer for the packetizer: accepts a nal and steps through its packets
module rtpnal_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  rtpnal_pkg::status_type status,
   output rtpnal_pkg::cmd_type    cmd
);
   import rtpnal_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SEND = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (!status.nal_empty) begin
                  state_in = ST_SEND;
               end
            end
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               cmd.advance = 1'b1;
               if (status.last_chunk) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/rtpnal_dp.sv =====
// datapath: nal context, fragment offset and remainder, sequence counter, packet fields
module rtpnal_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  rtpnal_pkg::cmd_type    cmd,
   output rtpnal_pkg::status_type status,
   input  rtpnal_pkg::req_type    req_data,
   input  logic [7:0]             video_channel,
   input  logic [6:0]             payload_kind,
   output rtpnal_pkg::rsp_type    rsp_data
);
   import rtpnal_pkg::*;

   logic [1:0]  pcount_ff,  pcount_in;
   logic [7:0]  p0_ff,      p0_in;
   logic [7:0]  p1_ff,      p1_in;
   logic [5:0]  ftype_ff,   ftype_in;
   logic [31:0] stamp_ff;
   logic        lastnal_ff;
   logic [15:0] off_ff,     off_in;
   logic [15:0] remain_ff,  remain_in;
   logic        first_ff;
   logic [15:0] seq_ff;

   logic        single;
   logic [10:0] max_chunk;
   logic [10:0] chunk;
   logic        end_chunk;
   logic [7:0]  fu_byte;

   // context of the next nal
   always_comb begin
      single = (req_data.nal_length <= {5'd0, MAX_PAYLOAD});
      if (single) begin
         pcount_in = PCOUNT_SINGLE;
         p0_in     = 8'd0;
         p1_in     = 8'd0;
         ftype_in  = 6'd0;
         off_in    = 16'd0;
      end else if (req_data.is_h265) begin
         pcount_in = PCOUNT_H265;
         p0_in     = (req_data.nal_head0 & H265_KEEP_MASK) | {H265_FU_TYPE[6:0], 1'b0};
         p1_in     = req_data.nal_head1;
         ftype_in  = req_data.nal_head0[6:1];
         off_in    = 16'd2;
      end else begin
         pcount_in = PCOUNT_FUA;
         p0_in     = (req_data.nal_head0 & FUA_NRI_MASK) | FUA_TYPE;
         p1_in     = 8'd0;
         ftype_in  = {1'b0, req_data.nal_head0[4:0]};
         off_in    = 16'd1;
      end
      remain_in = req_data.nal_length - off_in;
   end

   // current fragment
   always_comb begin
      max_chunk = MAX_PAYLOAD - {9'd0, pcount_ff};
      end_chunk = (remain_ff <= {5'd0, max_chunk});
      chunk     = end_chunk ? remain_ff[10:0] : max_chunk;
      fu_byte   = (first_ff ? FU_START_BIT : 8'd0) | (end_chunk ? FU_END_BIT : 8'd0)
                  | {2'd0, ftype_ff};
   end

   assign status.nal_empty  = (req_data.nal_length == 16'd0);
   assign status.last_chunk = end_chunk;

   always_comb begin
      rsp_data.channel      = video_channel;
      rsp_data.rtp_length   = RTP_HDR_LEN + {9'd0, pcount_ff} + chunk;
      rsp_data.header_byte1 = {lastnal_ff & end_chunk, payload_kind};
      rsp_data.sequence_res = seq_ff;
      rsp_data.stamp_out    = stamp_ff;
      rsp_data.prefix_count = pcount_ff;
      rsp_data.prefix0      = p0_ff;
      rsp_data.copy_offset  = off_ff;
      rsp_data.copy_length  = chunk;
      rsp_data.last         = end_chunk;
      case (pcount_ff)
         PCOUNT_H265: begin
            rsp_data.prefix1 = p1_ff;
            rsp_data.prefix2 = fu_byte;
         end
         PCOUNT_FUA: begin
            rsp_data.prefix1 = fu_byte;
            rsp_data.prefix2 = 8'd0;
         end
         default: begin
            rsp_data.prefix1 = 8'd0;
            rsp_data.prefix2 = 8'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pcount_ff  <= pcount_in;
         p0_ff      <= p0_in;
         p1_ff      <= p1_in;
         ftype_ff   <= ftype_in;
         stamp_ff   <= req_data.timestamp;
         lastnal_ff <= req_data.unit_end;
         off_ff     <= off_in;
         remain_ff  <= remain_in;
         first_ff   <= 1'b1;
      end else if (cmd.advance) begin
         off_ff     <= off_ff + {5'd0, chunk};
         remain_ff  <= remain_ff - {5'd0, chunk};
         first_ff   <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= 16'd0;
      end else if (cmd.advance) begin
         seq_ff <= seq_ff + 16'd1;
      end
   end

endmodule

// ===== rtl/core/rtp_nal_packetizer.sv =====
// top level of the rtp nal packetizer: register port, sequencer and datapath
//
// Takes one H.264 or H.265 NAL unit descriptor per transfer and gives one RTP packet
// descriptor per transfer on the result side: a single packet for up to 1400 bytes,
// otherwise FU-A or type 49 fragments with start and end bits. The sequencer walks the
// fragments one per cycle while the result side does not stall; the input is held off from
// acceptance until the final packet of the current NAL has been taken, and a zero-length
// NAL is accepted and gives nothing. The sequence number runs on across NALs and wraps at
// 65536. Channel and payload type sit at byte addresses 0 and 4.
module rtp_nal_packetizer (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rtpnal_pkg::req_type                    req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output rtpnal_pkg::rsp_type                    rsp_data,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [rtpnal_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [rtpnal_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [rtpnal_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                   pready
);
   import rtpnal_pkg::*;

   logic [7:0] video_channel_ff;
   logic [6:0] payload_kind_ff;
   logic       csr_write;
   cmd_type    cmd;
   status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         video_channel_ff <= VIDEO_CHANNEL_RST;
         payload_kind_ff  <= PAYLOAD_KIND_RST;
      end else if (csr_write) begin
         unique case (paddr[2])
            REG_VIDEO_CHANNEL: video_channel_ff <= pwdata[7:0];
            REG_PAYLOAD_KIND:  payload_kind_ff  <= pwdata[6:0];
            default: begin
               video_channel_ff <= video_channel_ff;
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_VIDEO_CHANNEL: prdata = {24'd0, video_channel_ff};
         REG_PAYLOAD_KIND:  prdata = {25'd0, payload_kind_ff};
         default:           prdata = '0;
      endcase
   end

   rtpnal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rtpnal_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data      (req_data),
      .video_channel (video_channel_ff),
      .payload_kind  (payload_kind_ff),
      .rsp_data      (rsp_data)
   );

endmodule

// ===== rtl/core/rtpnal_checker.sv =====
// port-level checks for the packetizer and their binding to the top level
module rtpnal_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_stall,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input rtpnal_pkg::rsp_type rsp_data
);
   import rtpnal_pkg::*;

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // no new nal taken while packets are still going out
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input accepted during packet output");

   // fragments follow on with the next sequence number and contiguous offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid
         && rsp_data.sequence_res == 16'($past(rsp_data.sequence_res) + 16'd1)
         && rsp_data.copy_offset == 16'($past(rsp_data.copy_offset)
                                        + {5'd0, $past(rsp_data.copy_length)}))
      else $error("fragment sequence or offset broken");

   // packet length covers header, prefix and copied bytes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.rtp_length ==
         RTP_HDR_LEN + {9'd0, rsp_data.prefix_count} + rsp_data.copy_length)
      else $error("rtp length mismatch");

   // marker only on the final packet of a nal
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.header_byte1[7] |-> rsp_data.last)
      else $error("marker on a non-final packet");

endmodule

bind rtp_nal_packetizer rtpnal_checker u_rtpnal_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
